/* design/rde_pkg.sv */
// shared types, command codes and constants of the raster draw engine
`timescale 1ns / 1ps
package rde_pkg;

    // default geometry and queue size
    localparam int SCREEN_WIDTH_DEF = 84;
    localparam int PAGE_ROWS_DEF    = 6;
    localparam int QUEUE_DEPTH_DEF  = 4;

    // coordinate width, signed, wide enough for every shape corner
    localparam int CW         = 12;
    localparam int CELL_BYTES = 6;

    // command codes on the input channel
    localparam logic [3:0] CMD_CLEAR      = 4'd0;
    localparam logic [3:0] CMD_PIXEL      = 4'd1;
    localparam logic [3:0] CMD_LINE       = 4'd2;
    localparam logic [3:0] CMD_RECT       = 4'd3;
    localparam logic [3:0] CMD_FILLRECT   = 4'd4;
    localparam logic [3:0] CMD_CIRCLE     = 4'd5;
    localparam logic [3:0] CMD_FILLCIRCLE = 4'd6;
    localparam logic [3:0] CMD_INVROW     = 4'd7;
    localparam logic [3:0] CMD_INVCELL    = 4'd8;
    localparam logic [3:0] CMD_SHL        = 4'd9;
    localparam logic [3:0] CMD_SHR        = 4'd10;
    localparam logic [3:0] CMD_READ       = 4'd11;

    typedef logic signed [CW-1:0] coord_t;

    typedef enum logic [3:0] {
        OP_CLEAR, OP_PIXEL, OP_LINE, OP_RECT, OP_FILLRECT, OP_CIRCLE,
        OP_FILLCIRCLE, OP_INVROW, OP_INVCELL, OP_SHL, OP_SHR, OP_READ, OP_NOP
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] xa;
        logic [7:0] ya;
        logic [7:0] xb;
        logic [7:0] yb;
        logic [6:0] radius;
        logic [8:0] byte_address;
    } cmd_t;

    // push group from the front end into the queue
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } push_t;

    typedef enum logic [2:0] {
        B_CLEAR, B_IDLE, B_STEP, B_WR, B_RESP
    } bstate_t;

    typedef enum logic [2:0] {
        MK_NONE, MK_OR, MK_INV, MK_COPY, MK_ZERO, MK_READ
    } memop_t;

    function automatic coord_t u2c(input logic [7:0] v);
        return coord_t'({1'b0, v});
    endfunction

endpackage

/* design/rde_front.sv */
// front end: takes commands off the input channel and classifies them
`timescale 1ns / 1ps
module rde_front
    import rde_pkg::*;
(
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [3:0]  s_tuser,
    input  logic        q_full,
    input  logic        init_busy,
    output push_t       push
);

    op_t op_dec;

    always_comb begin
        unique case (s_tuser)
            CMD_CLEAR:      op_dec = OP_CLEAR;
            CMD_PIXEL:      op_dec = OP_PIXEL;
            CMD_LINE:       op_dec = OP_LINE;
            CMD_RECT:       op_dec = OP_RECT;
            CMD_FILLRECT:   op_dec = OP_FILLRECT;
            CMD_CIRCLE:     op_dec = OP_CIRCLE;
            CMD_FILLCIRCLE: op_dec = OP_FILLCIRCLE;
            CMD_INVROW:     op_dec = OP_INVROW;
            CMD_INVCELL:    op_dec = OP_INVCELL;
            CMD_SHL:        op_dec = OP_SHL;
            CMD_SHR:        op_dec = OP_SHR;
            CMD_READ:       op_dec = OP_READ;
            default:        op_dec = OP_NOP;
        endcase
    end

    // no commands during the clearing pass after reset
    assign s_tready = aresetn && !q_full && !init_busy;

    always_comb begin
        push.valid            = s_tvalid && s_tready;
        push.cmd.op           = op_dec;
        push.cmd.xa           = s_tdata[7:0];
        push.cmd.ya           = s_tdata[15:8];
        push.cmd.xb           = s_tdata[23:16];
        push.cmd.yb           = s_tdata[31:24];
        push.cmd.radius       = s_tdata[38:32];
        push.cmd.byte_address = s_tdata[47:39];
    end

endmodule

/* design/rde_cmd_queue.sv */
// short command queue between front end and drawing back end
`timescale 1ns / 1ps
module rde_cmd_queue
    import rde_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  push_t push,
    input  logic  pop,
    output cmd_t  head,
    output logic  empty,
    output logic  full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmd_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   cnt_reg, cnt_next;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == (PW+1)'(DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push.valid) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push.valid && pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            slot_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

/* design/rde_back.sv */
// back end: shape sequencer, frame store and result register
`timescale 1ns / 1ps
module rde_back
    import rde_pkg::*;
#(
    parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
    parameter int PAGE_ROWS    = PAGE_ROWS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cmd_t       q_head,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       init_busy,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic       m_clipped
);

    localparam int W   = SCREEN_WIDTH;
    localparam int N   = SCREEN_WIDTH * PAGE_ROWS;
    localparam int H   = PAGE_ROWS * 8;
    localparam int AW  = $clog2(N);
    localparam int IW  = (AW > 9) ? AW : 9;
    localparam int PGW = (PAGE_ROWS > 1) ? $clog2(PAGE_ROWS) : 1;

    // frame store
    logic [7:0]    mem [N];
    logic [7:0]    mem_q_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [7:0]    mem_wd;

    bstate_t st_reg, st_next;
    logic    init_reg, init_next;
    cmd_t    cmd_reg, cmd_next;
    logic [1:0]    phase_reg, phase_next;
    logic [2:0]    sub_reg, sub_next;
    logic [IW-1:0] i_reg, i_next;
    coord_t  j_reg, j_next;
    coord_t  px_reg, px_next, py_reg, py_next, e_reg, e_next;
    coord_t  qx_reg, qx_next, qy_reg, qy_next;
    coord_t  f_reg, f_next, ddx_reg, ddx_next, ddy_reg, ddy_next;
    logic [7:0] ax_reg, ax_next, ay_reg, ay_next;
    logic    sxn_reg, sxn_next, syn_reg, syn_next, steep_reg, steep_next;
    logic    clip_reg, clip_next, last_reg, last_next;
    memop_t  opk_reg, opk_next;
    logic [AW-1:0] wa_reg, wa_next;
    logic [7:0]    mask_reg, mask_next, rdata_reg, rdata_next;
    logic          mv_reg, mv_next, mc_reg, mc_next;
    logic [7:0]    md_reg, md_next;

    // step decode
    logic    pt_en, pt_on, step_last, clip_set;
    coord_t  pt_x, pt_y;
    memop_t  byte_op, fin_op;
    logic [AW-1:0] byte_addr, byte_src, plot_addr, fin_wa, fin_ra, row_base;
    logic [7:0]    fin_mask;
    coord_t  cx, cy, rr, maj, mnr, e_sum, lx, ly, cell_col, cq_y, fa, col, half;
    logic    l_step, row_ok, i_top;
    coord_t  sdx, sdy, hr;
    logic [7:0] hax, hay;

    assign init_busy   = init_reg;
    assign m_valid     = mv_reg;
    assign m_read_data = md_reg;
    assign m_clipped   = mc_reg;

    // next state
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            B_CLEAR: begin
                if (i_reg == IW'(N - 1)) begin
                    st_next = init_reg ? B_IDLE : B_RESP;
                end
            end
            B_IDLE: begin
                if (!q_empty) begin
                    st_next = (q_head.op == OP_CLEAR) ? B_CLEAR : B_STEP;
                end
            end
            B_STEP: begin
                if (fin_op != MK_NONE) begin
                    st_next = B_WR;
                end else if (step_last) begin
                    st_next = B_RESP;
                end
            end
            B_WR: begin
                st_next = last_reg ? B_RESP : B_STEP;
            end
            B_RESP: begin
                if (!mv_reg || m_ready) begin
                    st_next = B_IDLE;
                end
            end
            default: st_next = B_IDLE;
        endcase
    end

    // shape stepping: at most one pixel or byte per step
    always_comb begin
        cx   = u2c(cmd_reg.xa);
        cy   = u2c(cmd_reg.ya);
        rr   = u2c({1'b0, cmd_reg.radius});
        pt_en = 1'b0;
        pt_x  = '0;
        pt_y  = '0;
        byte_op   = MK_NONE;
        byte_addr = '0;
        byte_src  = '0;
        step_last = 1'b0;
        clip_set  = 1'b0;
        phase_next = phase_reg;
        sub_next   = sub_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        e_next     = e_reg;
        qx_next    = qx_reg;
        qy_next    = qy_reg;
        f_next     = f_reg;
        ddx_next   = ddx_reg;
        ddy_next   = ddy_reg;

        maj    = steep_reg ? u2c(ay_reg) : u2c(ax_reg);
        mnr    = steep_reg ? u2c(ax_reg) : u2c(ay_reg);
        e_sum  = e_reg + mnr;
        l_step = (e_sum >= maj);
        if (!steep_reg) begin
            lx = sxn_reg ? px_reg - coord_t'(1) : px_reg + coord_t'(1);
            ly = l_step ? (syn_reg ? py_reg - coord_t'(1) : py_reg + coord_t'(1)) : py_reg;
        end else begin
            ly = syn_reg ? py_reg - coord_t'(1) : py_reg + coord_t'(1);
            lx = l_step ? (sxn_reg ? px_reg - coord_t'(1) : px_reg + coord_t'(1)) : px_reg;
        end

        row_ok   = (32'(cmd_reg.ya) < PAGE_ROWS);
        row_base = AW'(cmd_reg.ya[PGW-1:0]) * AW'(W);
        cell_col = u2c(cmd_reg.xa) * coord_t'(CELL_BYTES) + coord_t'(i_reg);
        i_top    = (i_reg == IW'(N - 1));

        cq_y = qy_reg;
        fa   = f_reg;
        col  = '0;
        half = '0;

        case (cmd_reg.op)
            OP_PIXEL: begin
                pt_en = 1'b1;
                pt_x = cx;
                pt_y = cy;
                step_last = 1'b1;
            end
            OP_LINE: begin
                pt_en = 1'b1;
                case (phase_reg)
                    2'd0: begin
                        pt_x = cx;
                        pt_y = cy;
                        phase_next = 2'd1;
                    end
                    2'd1: begin
                        pt_x = u2c(cmd_reg.xb);
                        pt_y = u2c(cmd_reg.yb);
                        i_next = '0;
                        if (maj == '0) begin
                            step_last = 1'b1;
                        end else begin
                            phase_next = 2'd2;
                        end
                    end
                    default: begin
                        pt_x = lx;
                        pt_y = ly;
                        px_next = lx;
                        py_next = ly;
                        e_next = l_step ? e_sum - maj : e_sum;
                        i_next = i_reg + 1'b1;
                        step_last = ((i_reg + 1'b1) == IW'(maj[7:0]));
                    end
                endcase
            end
            OP_RECT: begin
                if (cmd_reg.xb == '0 || cmd_reg.yb == '0) begin
                    step_last = 1'b1;
                end else begin
                    pt_en = 1'b1;
                    if (phase_reg == 2'd0) begin
                        pt_x = cx + coord_t'(i_reg);
                        pt_y = sub_reg[0] ? cy + u2c(cmd_reg.yb) - coord_t'(1) : cy;
                    end else begin
                        pt_x = sub_reg[0] ? cx + u2c(cmd_reg.xb) - coord_t'(1) : cx;
                        pt_y = cy + coord_t'(i_reg);
                    end
                    sub_next = {2'b00, !sub_reg[0]};
                    if (sub_reg[0]) begin
                        i_next = i_reg + 1'b1;
                        if (phase_reg == 2'd0) begin
                            if ((i_reg + 1'b1) == IW'(cmd_reg.xb)) begin
                                phase_next = 2'd1;
                                i_next = '0;
                            end
                        end else begin
                            step_last = ((i_reg + 1'b1) == IW'(cmd_reg.yb));
                        end
                    end
                end
            end
            OP_FILLRECT: begin
                if (cmd_reg.xb == '0 || cmd_reg.yb == '0) begin
                    step_last = 1'b1;
                end else begin
                    pt_en = 1'b1;
                    pt_x = cx + coord_t'(i_reg);
                    pt_y = cy + j_reg;
                    if ((j_reg + coord_t'(1)) == u2c(cmd_reg.yb)) begin
                        j_next = '0;
                        i_next = i_reg + 1'b1;
                        step_last = ((i_reg + 1'b1) == IW'(cmd_reg.xb));
                    end else begin
                        j_next = j_reg + coord_t'(1);
                    end
                end
            end
            OP_CIRCLE, OP_FILLCIRCLE: begin
                case (phase_reg)
                    2'd0: begin
                        pt_en = 1'b1;
                        if (cmd_reg.op == OP_FILLCIRCLE) begin
                            pt_x = cx;
                            pt_y = cy + j_reg;
                            j_next = j_reg + coord_t'(1);
                            if (j_reg == rr) begin
                                phase_next = 2'd1;
                            end
                        end else begin
                            case (sub_reg[1:0])
                                2'd0: begin pt_x = cx;      pt_y = cy + rr; end
                                2'd1: begin pt_x = cx;      pt_y = cy - rr; end
                                2'd2: begin pt_x = cx + rr; pt_y = cy;      end
                                default: begin pt_x = cx - rr; pt_y = cy;   end
                            endcase
                            sub_next = sub_reg + 1'b1;
                            if (sub_reg[1:0] == 2'd3) begin
                                sub_next = '0;
                                phase_next = 2'd1;
                            end
                        end
                    end
                    2'd1: begin
                        // midpoint update, no pixel in this step
                        if (qx_reg < qy_reg) begin
                            if (f_reg >= 0) begin
                                cq_y = qy_reg - coord_t'(1);
                                ddy_next = ddy_reg + coord_t'(2);
                                fa = f_reg + ddy_reg + coord_t'(2);
                            end
                            qy_next = cq_y;
                            qx_next = qx_reg + coord_t'(1);
                            ddx_next = ddx_reg + coord_t'(2);
                            f_next = fa + ddx_reg + coord_t'(2);
                            phase_next = 2'd2;
                            sub_next = '0;
                            j_next = -cq_y;
                        end else begin
                            step_last = 1'b1;
                        end
                    end
                    default: begin
                        pt_en = 1'b1;
                        if (cmd_reg.op == OP_FILLCIRCLE) begin
                            case (sub_reg[1:0])
                                2'd0: begin col = cx + qx_reg; half = qy_reg; end
                                2'd1: begin col = cx - qx_reg; half = qy_reg; end
                                2'd2: begin col = cx + qy_reg; half = qx_reg; end
                                default: begin col = cx - qy_reg; half = qx_reg; end
                            endcase
                            pt_x = col;
                            pt_y = cy + j_reg;
                            if (j_reg == half) begin
                                if (sub_reg[1:0] == 2'd3) begin
                                    phase_next = 2'd1;
                                    sub_next = '0;
                                end else begin
                                    sub_next = sub_reg + 1'b1;
                                    j_next = (sub_reg[1:0] == 2'd0) ? -qy_reg : -qx_reg;
                                end
                            end else begin
                                j_next = j_reg + coord_t'(1);
                            end
                        end else begin
                            case (sub_reg)
                                3'd0: begin pt_x = cx + qx_reg; pt_y = cy + qy_reg; end
                                3'd1: begin pt_x = cx - qx_reg; pt_y = cy + qy_reg; end
                                3'd2: begin pt_x = cx + qx_reg; pt_y = cy - qy_reg; end
                                3'd3: begin pt_x = cx - qx_reg; pt_y = cy - qy_reg; end
                                3'd4: begin pt_x = cx + qy_reg; pt_y = cy + qx_reg; end
                                3'd5: begin pt_x = cx - qy_reg; pt_y = cy + qx_reg; end
                                3'd6: begin pt_x = cx + qy_reg; pt_y = cy - qx_reg; end
                                default: begin pt_x = cx - qy_reg; pt_y = cy - qx_reg; end
                            endcase
                            sub_next = sub_reg + 1'b1;
                            if (sub_reg == 3'd7) begin
                                phase_next = 2'd1;
                            end
                        end
                    end
                endcase
            end
            OP_INVROW: begin
                if (!row_ok) begin
                    clip_set = 1'b1;
                    step_last = 1'b1;
                end else begin
                    byte_op = MK_INV;
                    byte_addr = row_base + AW'(i_reg);
                    i_next = i_reg + 1'b1;
                    step_last = (i_reg == IW'(W - 1));
                end
            end
            OP_INVCELL: begin
                if (!row_ok) begin
                    clip_set = 1'b1;
                    step_last = 1'b1;
                end else begin
                    if (cell_col >= coord_t'(W)) begin
                        clip_set = 1'b1;
                    end else begin
                        byte_op = MK_INV;
                        byte_addr = row_base + AW'(cell_col);
                    end
                    i_next = i_reg + 1'b1;
                    step_last = (i_reg == IW'(CELL_BYTES - 1));
                end
            end
            OP_SHL: begin
                byte_addr = AW'(i_reg);
                byte_src  = AW'(i_reg) + 1'b1;
                if (j_reg == coord_t'(W - 1)) begin
                    byte_op = MK_ZERO;
                    j_next = '0;
                end else begin
                    byte_op = MK_COPY;
                    j_next = j_reg + coord_t'(1);
                end
                i_next = i_reg + 1'b1;
                step_last = i_top;
            end
            OP_SHR: begin
                byte_addr = AW'(i_reg);
                byte_src  = AW'(i_reg) - 1'b1;
                if (j_reg == '0) begin
                    byte_op = MK_ZERO;
                    j_next = coord_t'(W - 1);
                end else begin
                    byte_op = MK_COPY;
                    j_next = j_reg - coord_t'(1);
                end
                i_next = i_reg - 1'b1;
                step_last = (i_reg == '0);
            end
            OP_READ: begin
                if (32'(cmd_reg.byte_address) < N) begin
                    byte_op = MK_READ;
                    byte_addr = AW'(cmd_reg.byte_address);
                end else begin
                    clip_set = 1'b1;
                end
                step_last = 1'b1;
            end
            default: begin
                step_last = 1'b1;
            end
        endcase

        // pixel to byte address and bit mask, off-screen pixels dropped
        pt_on = !pt_x[CW-1] && !pt_y[CW-1] && (pt_x < coord_t'(W)) && (pt_y < coord_t'(H));
        plot_addr = AW'(pt_y[CW-1:3]) * AW'(W) + AW'(pt_x);
        fin_op   = byte_op;
        fin_wa   = byte_addr;
        fin_ra   = (byte_op == MK_COPY) ? byte_src : byte_addr;
        fin_mask = '0;
        if (pt_en) begin
            if (pt_on) begin
                fin_op   = MK_OR;
                fin_wa   = plot_addr;
                fin_ra   = plot_addr;
                fin_mask = 8'(1) << pt_y[2:0];
            end else begin
                clip_set = 1'b1;
            end
        end
    end

    // line and circle set-up from the queue head
    always_comb begin
        sdx = u2c(q_head.xb) - u2c(q_head.xa);
        sdy = u2c(q_head.yb) - u2c(q_head.ya);
        hax = sdx[CW-1] ? 8'(-sdx) : 8'(sdx);
        hay = sdy[CW-1] ? 8'(-sdy) : 8'(sdy);
        hr  = u2c({1'b0, q_head.radius});
    end

    // register next values per state
    always_comb begin
        init_next  = init_reg;
        cmd_next   = cmd_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        sxn_next   = sxn_reg;
        syn_next   = syn_reg;
        steep_next = steep_reg;
        clip_next  = clip_reg;
        last_next  = last_reg;
        opk_next   = opk_reg;
        wa_next    = wa_reg;
        mask_next  = mask_reg;
        rdata_next = rdata_reg;
        mv_next    = mv_reg;
        md_next    = md_reg;
        mc_next    = mc_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_wa     = wa_reg;
        mem_wd     = '0;
        mem_ra     = fin_ra;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        unique case (st_reg)
            B_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = AW'(i_reg);
                if (i_top) begin
                    init_next = 1'b0;
                end
            end
            B_IDLE: begin
                q_pop      = !q_empty;
                cmd_next   = q_head;
                clip_next  = 1'b0;
                rdata_next = '0;
                ax_next    = hax;
                ay_next    = hay;
                sxn_next   = sdx[CW-1];
                syn_next   = sdy[CW-1];
                steep_next = (hay > hax);
            end
            B_STEP: begin
                opk_next  = fin_op;
                wa_next   = fin_wa;
                mask_next = fin_mask;
                last_next = step_last;
                clip_next = clip_reg || clip_set;
            end
            B_WR: begin
                mem_we = (opk_reg != MK_READ);
                case (opk_reg)
                    MK_OR:   mem_wd = mem_q_reg | mask_reg;
                    MK_INV:  mem_wd = ~mem_q_reg;
                    MK_COPY: mem_wd = mem_q_reg;
                    default: mem_wd = '0;
                endcase
                if (opk_reg == MK_READ) begin
                    rdata_next = mem_q_reg;
                end
            end
            B_RESP: begin
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    md_next = rdata_reg;
                    mc_next = clip_reg;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // iterator registers: stepped in B_STEP, counted in B_CLEAR, set up in B_IDLE
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= B_CLEAR;
            init_reg <= 1'b1;
            i_reg    <= '0;
            mv_reg   <= 1'b0;
        end else begin
            st_reg   <= st_next;
            init_reg <= init_next;
            mv_reg   <= mv_next;
            if (st_reg == B_CLEAR) begin
                i_reg <= i_top ? '0 : i_reg + 1'b1;
            end else if (st_reg == B_IDLE) begin
                i_reg <= (q_head.op == OP_SHR) ? IW'(N - 1) : '0;
            end else if (st_reg == B_STEP) begin
                i_reg <= i_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        sxn_reg   <= sxn_next;
        syn_reg   <= syn_next;
        steep_reg <= steep_next;
        clip_reg  <= clip_next;
        last_reg  <= last_next;
        opk_reg   <= opk_next;
        wa_reg    <= wa_next;
        mask_reg  <= mask_next;
        rdata_reg <= rdata_next;
        md_reg    <= md_next;
        mc_reg    <= mc_next;
        if (st_reg == B_IDLE) begin
            phase_reg <= '0;
            sub_reg   <= '0;
            j_reg     <= (q_head.op == OP_FILLCIRCLE) ? -hr :
                         (q_head.op == OP_SHR) ? coord_t'(W - 1) : '0;
            px_reg    <= u2c(q_head.xa);
            py_reg    <= u2c(q_head.ya);
            e_reg     <= ((hay > hax) ? u2c(hay) : u2c(hax)) >>> 1;
            qx_reg    <= '0;
            qy_reg    <= hr;
            f_reg     <= coord_t'(1) - hr;
            ddx_reg   <= coord_t'(1);
            ddy_reg   <= -(hr + hr);
        end else if (st_reg == B_STEP) begin
            phase_reg <= phase_next;
            sub_reg   <= sub_next;
            j_reg     <= j_next;
            px_reg    <= px_next;
            py_reg    <= py_next;
            e_reg     <= e_next;
            qx_reg    <= qx_next;
            qy_reg    <= qy_next;
            f_reg     <= f_next;
            ddx_reg   <= ddx_next;
            ddy_reg   <= ddy_next;
        end
    end

    // frame store: one write and one registered read a cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        mem_q_reg <= mem[mem_ra];
    end

endmodule

/* design/monochrome_raster_draw_engine_top.sv */
// top level of the monochrome raster draw engine
`timescale 1ns / 1ps
// monochrome raster draw engine
// draws into a frame store of SCREEN_WIDTH columns by PAGE_ROWS pages of
// vertical 8-pixel bytes; commands arrive on the s_ channel, and each one
// yields exactly one result transaction on the m_ channel (read byte and
// off-screen flag)
// cost: every touched pixel or byte costs one read-modify-write in the
// frame store, a read in B_STEP and the write in B_WR, plus the states to
// start and answer; a clear writes one byte per cycle (504 bytes at the
// default size), a shift rewrites every byte, a line every pixel, and a
// circle each pixel plus one update step without a pixel per octant step
// the queue takes up to QUEUE_DEPTH further commands while one is drawn
// reset: the frame store is swept to zero, one byte a cycle, with
// s_tready low until the sweep ends
// a stalled receiver holds the result in the output register; the back
// end then waits, while the queue keeps accepting until it is full
module monochrome_raster_draw_engine_top
    import rde_pkg::*;
#(
    parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
    parameter int PAGE_ROWS    = PAGE_ROWS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // xa[7:0], ya[15:8], xb[23:16], yb[31:24],
                                  // radius[38:32], byte_address[47:39]
    input  logic [3:0]  s_tuser,  // cmd[3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // read_data[7:0], clipped[8], zero above
);

    push_t push;
    cmd_t  q_head;
    logic  q_empty, q_full, q_pop, init_busy;
    logic [7:0] read_data;
    logic       clipped;

    // accept and classify
    rde_front u_front (
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .init_busy (init_busy),
        .push      (push)
    );

    // decoupling queue
    rde_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (q_pop),
        .head    (q_head),
        .empty   (q_empty),
        .full    (q_full)
    );

    // drawing sequencer and frame store
    rde_back #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .PAGE_ROWS    (PAGE_ROWS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_head      (q_head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .init_busy   (init_busy),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_read_data (read_data),
        .m_clipped   (clipped)
    );

    assign m_tdata = {7'b0, clipped, read_data};

endmodule

/* design/rde_checker.sv */
// port-level checks on the raster draw engine, bound to the top level
`timescale 1ns / 1ps
module rde_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a result stays offered until taken
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn before it was taken");

    // a stalled result keeps its data
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("stalled result changed");

    // no result and no intake right after reset, the store is being swept
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("activity straight after reset");

    // padding bits above the flag are always zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:9] == 7'b0)
        else $error("result padding not zero");

endmodule

bind monochrome_raster_draw_engine_top rde_checker u_rde_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
